// ===== hdl/ntcbte_pkg.sv =====
`timescale 1ns / 1ps

package ntcbte_pkg;

    localparam int unsigned VW     = 12;   // divider voltage, mV
    localparam int unsigned PULLW  = 20;
    localparam int unsigned BETAW  = 14;
    localparam int unsigned NOMW   = 20;
    localparam int unsigned T0W    = 16;
    localparam int unsigned ALPHAW = 16;
    localparam int unsigned SUPW   = 12;
    localparam int unsigned TW     = 16;   // temperature, 0.01 C

    // quotient width of the beta division (dividend bits)
    localparam int unsigned QW = 54;

    // register indexes
    localparam logic [2:0] REG_PULLUP  = 3'd0;
    localparam logic [2:0] REG_BETA    = 3'd1;
    localparam logic [2:0] REG_NOMINAL = 3'd2;
    localparam logic [2:0] REG_T0      = 3'd3;
    localparam logic [2:0] REG_ALPHA   = 3'd4;
    localparam logic [2:0] REG_SUPPLY  = 3'd5;

    typedef struct packed {
        logic [PULLW-1:0]  pullup_ohms;
        logic [BETAW-1:0]  beta_kelvin;
        logic [NOMW-1:0]   nominal_ohms;
        logic [T0W-1:0]    reference_centikelvin;
        logic [ALPHAW-1:0] smoothing_q16;
        logic [SUPW-1:0]   supply_mv;
    } cfg_t;

    typedef struct packed {
        logic load_in;    // capture input beat
        logic check;      // range check, beta*100
        logic mul;        // operand product into mantissa
        logic second;     // second operand of the log pair
        logic shift;      // one normalize step
        logic tab;        // table index and remainder
        logic rd;         // table read
        logic intp;       // interpolate, store log
        logic ln1;        // d * low half of ln2
        logic ln2;        // add d * high half
        logic ln3;        // round to Q16
        logic den;        // denominator and numerator
        logic div_init;
        logic div_step;
        logic tfin;       // quotient to celsius
        logic tmax;       // unbounded temperature
        logic ema1;
        logic ema2;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic fault;
        logic mant_msb;
        logic den_pos;
    } sts_t;

endpackage

// ===== hdl/ntc_beta_temperature_ema_top.sv =====
`timescale 1ns / 1ps

// NTC thermistor temperature with an exponential moving average. Each input
// beat carries one divider voltage in mV (thermistor below a pull-up across the
// supply); the block forms the thermistor resistance ratio as two products,
// takes a fixed-point log2 of each (leading-one normalize plus an interpolated
// table), converts to ln, solves the beta equation with a restoring divider
// and feeds the temperature (0.01 C) to an EMA that resets to 25.00 C. Each
// beat gives exactly one result beat carrying the filtered value; a voltage of
// zero or not below the supply sets the fault flag and leaves the filter as is.
// The normalize shifts (up to 31 for each of the two logs) and the 54 divider
// iterations dominate an item; an unbounded temperature skips the divider and a
// fault item goes straight from the range check to the output. Only one item
// is in flight; a new beat is taken while the last result still waits in the
// output register. Registers must be written through the APB port only while
// the block is idle; the block itself does not enforce this.
module ntc_beta_temperature_ema_top #(
    parameter int unsigned LOG_TABLE_ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // apb config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] divider_mv
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] filtered_centi_c
    output logic [0:0]  m_tuser    // [0] fault
);
    import ntcbte_pkg::*;

    cfg_t       cfg_reg;
    cmd_t       cmd;
    sts_t       sts;
    logic [2:0] reg_idx;
    logic       wr_en;
    logic signed [TW-1:0] out_temp;
    logic       out_fault;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register file, reset to the nominal 10k / 3950 part on 3.3 V
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pullup_ohms           <= 20'd10000;
            cfg_reg.beta_kelvin           <= 14'd3950;
            cfg_reg.nominal_ohms          <= 20'd10000;
            cfg_reg.reference_centikelvin <= 16'd29815;
            cfg_reg.smoothing_q16         <= 16'd6554;
            cfg_reg.supply_mv             <= 12'd3300;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PULLUP:  cfg_reg.pullup_ohms           <= pwdata[PULLW-1:0];
                REG_BETA:    cfg_reg.beta_kelvin           <= pwdata[BETAW-1:0];
                REG_NOMINAL: cfg_reg.nominal_ohms          <= pwdata[NOMW-1:0];
                REG_T0:      cfg_reg.reference_centikelvin <= pwdata[T0W-1:0];
                REG_ALPHA:   cfg_reg.smoothing_q16         <= pwdata[ALPHAW-1:0];
                REG_SUPPLY:  cfg_reg.supply_mv             <= pwdata[SUPW-1:0];
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_PULLUP:  prdata = 32'(cfg_reg.pullup_ohms);
            REG_BETA:    prdata = 32'(cfg_reg.beta_kelvin);
            REG_NOMINAL: prdata = 32'(cfg_reg.nominal_ohms);
            REG_T0:      prdata = 32'(cfg_reg.reference_centikelvin);
            REG_ALPHA:   prdata = 32'(cfg_reg.smoothing_q16);
            REG_SUPPLY:  prdata = 32'(cfg_reg.supply_mv);
            default:     prdata = '0;
        endcase
    end

    // sequencer
    ntcbte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // arithmetic: products, log unit, divider, filter, output register
    ntcbte_dp #(
        .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_mv     (s_tdata[VW-1:0]),
        .cmd       (cmd),
        .sts       (sts),
        .out_temp  (out_temp),
        .out_fault (out_fault)
    );

    assign m_tdata    = out_temp;
    assign m_tuser[0] = out_fault;

endmodule

// ===== hdl/ntcbte_ctrl.sv =====
`timescale 1ns / 1ps

module ntcbte_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output ntcbte_pkg::cmd_t  cmd,
    input  ntcbte_pkg::sts_t  sts
);
    import ntcbte_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CHK  = 5'd1;
    localparam logic [4:0] S_MUL  = 5'd2;
    localparam logic [4:0] S_NORM = 5'd3;
    localparam logic [4:0] S_TAB  = 5'd4;
    localparam logic [4:0] S_RD   = 5'd5;
    localparam logic [4:0] S_INTP = 5'd6;
    localparam logic [4:0] S_LN1  = 5'd7;
    localparam logic [4:0] S_LN2  = 5'd8;
    localparam logic [4:0] S_LN3  = 5'd9;
    localparam logic [4:0] S_DEN  = 5'd10;
    localparam logic [4:0] S_DCHK = 5'd11;
    localparam logic [4:0] S_DIV  = 5'd12;
    localparam logic [4:0] S_TFIN = 5'd13;
    localparam logic [4:0] S_EMA1 = 5'd14;
    localparam logic [4:0] S_EMA2 = 5'd15;
    localparam logic [4:0] S_OUT  = 5'd16;

    localparam int unsigned CW = $clog2(QW);

    logic [4:0]    state_reg, state_next;
    logic          second_reg, second_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          mvalid_reg, mvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            second_reg <= second_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        second_next = second_reg;
        cnt_next    = cnt_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd         = '0;
        cmd.second  = second_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHK;
                end
            end
            S_CHK: begin
                cmd.check   = 1'b1;
                second_next = 1'b0;
                state_next  = sts.fault ? S_OUT : S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_NORM;
            end
            S_NORM: begin
                if (sts.mant_msb) begin
                    state_next = S_TAB;
                end else begin
                    cmd.shift = 1'b1;
                end
            end
            S_TAB: begin
                cmd.tab    = 1'b1;
                state_next = S_RD;
            end
            S_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_INTP;
            end
            S_INTP: begin
                cmd.intp = 1'b1;
                if (second_reg) begin
                    state_next = S_LN1;
                end else begin
                    second_next = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_LN1: begin
                cmd.ln1    = 1'b1;
                state_next = S_LN2;
            end
            S_LN2: begin
                cmd.ln2    = 1'b1;
                state_next = S_LN3;
            end
            S_LN3: begin
                cmd.ln3    = 1'b1;
                state_next = S_DEN;
            end
            S_DEN: begin
                cmd.den    = 1'b1;
                state_next = S_DCHK;
            end
            S_DCHK: begin
                if (sts.den_pos) begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end else begin
                    cmd.tmax   = 1'b1;
                    state_next = S_EMA1;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1)) begin
                    state_next = S_TFIN;
                end
            end
            S_TFIN: begin
                cmd.tfin   = 1'b1;
                state_next = S_EMA1;
            end
            S_EMA1: begin
                cmd.ema1   = 1'b1;
                state_next = S_EMA2;
            end
            S_EMA2: begin
                cmd.ema2   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ntcbte_dp.sv =====
`timescale 1ns / 1ps

module ntcbte_dp #(
    parameter int unsigned LOG_TABLE_ENTRIES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ntcbte_pkg::cfg_t              cfg,
    input  logic [ntcbte_pkg::VW-1:0]     in_mv,
    input  ntcbte_pkg::cmd_t              cmd,
    output ntcbte_pkg::sts_t              sts,
    output logic signed [ntcbte_pkg::TW-1:0] out_temp,
    output logic                          out_fault
);
    import ntcbte_pkg::*;

    localparam int unsigned N   = LOG_TABLE_ENTRIES;
    localparam int unsigned IW  = $clog2(N);
    localparam int unsigned NW  = $clog2(N + 1);
    localparam logic [14:0] LN2_LO = 15'(744261118 % 32768);
    localparam logic [14:0] LN2_HI = 15'(744261118 / 32768);

    // log2(1 + i/n) in Q16 by repeated squaring, elaboration only
    function automatic logic [16:0] log2_unit(input int unsigned n, input int unsigned i);
        logic [63:0] num;
        logic [63:0] r;
        logic [63:0] y;
        logic [63:0] bits;
        int          k;
        num  = 64'(n + i) << 30;
        r    = '0;
        y    = '0;
        bits = '0;
        for (k = 63; k >= 0; k--) begin
            r = {r[62:0], num[k]};
            y = y << 1;
            if (r >= 64'(n)) begin
                r    = r - 64'(n);
                y[0] = 1'b1;
            end
        end
        if (y >= (64'd2 << 30)) begin
            return 17'd65536;
        end
        for (k = 0; k < 20; k++) begin
            y    = (y * y) >> 30;
            bits = bits << 1;
            if (y >= (64'd2 << 30)) begin
                y       = y >> 1;
                bits[0] = 1'b1;
            end
        end
        return 17'((bits + 64'd8) >> 4);
    endfunction

    function automatic logic signed [TW-1:0] sat16(input logic signed [54:0] x);
        if (x > 55'sd32767) begin
            return 16'sh7fff;
        end
        if (x < -55'sd32768) begin
            return 16'sh8000;
        end
        return x[TW-1:0];
    endfunction

    logic [16:0] log_tab [0:N];

    for (genvar gi = 0; gi <= N; gi++) begin : g_tab
        assign log_tab[gi] = log2_unit(N, gi);
    end

    logic [VW-1:0]           v_reg;
    logic                    fault_reg;
    logic [20:0]             b100_reg;
    logic [31:0]             mant_reg;
    logic [4:0]              p_reg;
    logic [IW-1:0]           idx_reg;
    logic [30:0]             rem_reg;
    logic [16:0]             a_reg, b_reg;
    logic [21:0]             l1_reg;
    logic signed [22:0]      d_reg;
    logic signed [54:0]      acc_reg;
    logic signed [22:0]      ln_reg;
    logic signed [39:0]      den_reg;
    logic [36:0]             bt_reg;
    logic [QW-1:0]           q_reg;
    logic [38:0]             r_reg;
    logic signed [TW-1:0]    temp_reg;
    logic signed [33:0]      ema_reg;
    logic signed [TW-1:0]    filt_reg;
    logic signed [TW-1:0]    otemp_reg;
    logic                    ofault_reg;

    logic [PULLW-1:0] pull_nz;
    logic [BETAW-1:0] beta_nz;
    logic [NOMW-1:0]  nom_nz;
    logic [T0W-1:0]   t0_nz;

    assign pull_nz = (cfg.pullup_ohms == '0) ? PULLW'(1) : cfg.pullup_ohms;
    assign beta_nz = (cfg.beta_kelvin == '0) ? BETAW'(1) : cfg.beta_kelvin;
    assign nom_nz  = (cfg.nominal_ohms == '0) ? NOMW'(1) : cfg.nominal_ohms;
    assign t0_nz   = (cfg.reference_centikelvin == '0) ? T0W'(1) : cfg.reference_centikelvin;

    logic [19:0]             mul_a;
    logic [11:0]             mul_b;
    logic [31+IW-1:0]        tprod;
    logic [16:0]             diff;
    logic [47:0]             iprod;
    logic [21:0]             log_val;
    logic signed [38:0]      mlo, mhi;
    logic signed [39:0]      tln;
    logic [38:0]             rs;
    logic [38:0]             dd;
    logic signed [16:0]      delta;
    logic signed [17:0]      step;
    logic signed [54:0]      fsum;

    assign mul_a   = cmd.second ? nom_nz : pull_nz;
    assign mul_b   = cmd.second ? (cfg.supply_mv - v_reg) : v_reg;
    assign tprod   = {mant_reg[30:0]} * NW'(N);
    assign diff    = b_reg - a_reg;
    assign iprod   = diff * rem_reg;
    assign log_val = 22'({p_reg, 16'b0}) + 22'(a_reg) + 22'(iprod[47:31]);
    assign mlo     = d_reg * $signed({1'b0, LN2_LO});
    assign mhi     = d_reg * $signed({1'b0, LN2_HI});
    assign tln     = $signed({1'b0, t0_nz}) * ln_reg;
    assign rs      = {r_reg[37:0], q_reg[QW-1]};
    assign dd      = den_reg[38:0];
    assign delta   = 17'(temp_reg) - 17'(filt_reg);
    assign step    = 18'((ema_reg + 34'sd32768) >>> 16);
    assign fsum    = 55'(filt_reg) + 55'(step);

    assign sts.fault    = (v_reg == '0) || (v_reg >= cfg.supply_mv);
    assign sts.mant_msb = mant_reg[31];
    assign sts.den_pos  = (den_reg > 40'sd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg <= 16'sd2500;
        end else if (cmd.ema2) begin
            filt_reg <= sat16(fsum);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            v_reg <= in_mv;
        end
        if (cmd.check) begin
            fault_reg <= sts.fault;
            b100_reg  <= 21'(beta_nz) * 7'd100;
        end
        if (cmd.mul) begin
            mant_reg <= mul_a * mul_b;
            p_reg    <= 5'd31;
        end else if (cmd.shift) begin
            mant_reg <= mant_reg << 1;
            p_reg    <= p_reg - 5'd1;
        end
        if (cmd.tab) begin
            idx_reg <= tprod[31+IW-1:31];
            rem_reg <= tprod[30:0];
        end
        if (cmd.rd) begin
            a_reg <= log_tab[{1'b0, idx_reg}];
            b_reg <= log_tab[{1'b0, idx_reg} + 1'b1];
        end
        if (cmd.intp) begin
            if (cmd.second) begin
                d_reg <= $signed({1'b0, l1_reg}) - $signed({1'b0, log_val});
            end else begin
                l1_reg <= log_val;
            end
        end
        if (cmd.ln1) begin
            acc_reg <= 55'(mlo);
        end
        if (cmd.ln2) begin
            acc_reg <= acc_reg + (55'(mhi) <<< 15);
        end
        if (cmd.ln3) begin
            ln_reg <= 23'((acc_reg + (55'sd1 <<< 29)) >>> 30);
        end
        if (cmd.den) begin
            den_reg <= $signed({3'b0, b100_reg, 16'b0}) + tln;
            bt_reg  <= b100_reg * t0_nz;
        end
        if (cmd.div_init) begin
            q_reg <= {1'b0, bt_reg, 16'b0} + QW'(den_reg[39:1]);
            r_reg <= '0;
        end else if (cmd.div_step) begin
            if (rs >= dd) begin
                r_reg <= rs - dd;
                q_reg <= {q_reg[QW-2:0], 1'b1};
            end else begin
                r_reg <= rs;
                q_reg <= {q_reg[QW-2:0], 1'b0};
            end
        end
        if (cmd.tfin) begin
            temp_reg <= sat16($signed({1'b0, q_reg}) - 55'sd27315);
        end else if (cmd.tmax) begin
            temp_reg <= 16'sh7fff;
        end
        if (cmd.ema1) begin
            ema_reg <= $signed({1'b0, cfg.smoothing_q16}) * delta;
        end
        if (cmd.out_load) begin
            otemp_reg  <= filt_reg;
            ofault_reg <= fault_reg;
        end
    end

    assign out_temp  = otemp_reg;
    assign out_fault = ofault_reg;

endmodule

// ===== test/ntc_beta_temperature_ema_top_test.sv =====
`timescale 1ns / 1ps

module ntc_beta_temperature_ema_top_test;
    import ntcbte_pkg::*;

    localparam int TABLE_N   = 64;
    localparam longint LN2_Q30 = 744261118;
    localparam int MAX_CYCLES = 2_000_000;

    typedef struct packed {
        logic signed [TW-1:0] temp;
        logic                 fault;
    } reading_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    ntc_beta_temperature_ema_top #(.LOG_TABLE_ENTRIES(TABLE_N)) dut (.*);

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state: registers, filter and log2 table
    logic [31:0] cfg_regs [6];
    logic signed [15:0] ema_temp;
    longint log2_table [TABLE_N+1];

    logic [VW-1:0] voltage_q [$];
    reading_t      reading_q [$];
    int  fail_count = 0;
    int  cycle_count = 0;
    int  gap_left = 0;
    int  hold_left = 0;
    bit  long_hold_req = 0;
    bit  s_tready_seen = 0;

    function automatic longint floor_shift(longint x, int n);
        return x >>> n;     // arithmetic shift is a floor
    endfunction

    function automatic longint unit_log2(longint unsigned y);
        longint unsigned bits;
        bits = 0;
        if (y >= (64'd2 << 30)) return 65536;
        for (int k = 0; k < 20; k++) begin
            y = (y * y) >> 30;
            bits = bits << 1;
            if (y >= (64'd2 << 30)) begin
                y = y >> 1;
                bits = bits | 1;
            end
        end
        return longint'((bits + 8) >> 4);
    endfunction

    function automatic longint log2_fixed(longint unsigned x);
        int p;
        longint unsigned m, f, prod, idx, rem;
        longint a, b;
        p = 0;
        while (p < 31 && (x >> (p + 1)) != 0) p++;
        m = (x << (31 - p)) & 64'hFFFF_FFFF;
        f = m & 64'h7FFF_FFFF;
        prod = f * TABLE_N;
        idx = prod >> 31;
        rem = prod & 64'h7FFF_FFFF;
        if (idx >= TABLE_N) begin
            idx = TABLE_N - 1;
            rem = 64'h7FFF_FFFF;
        end
        a = log2_table[idx];
        b = log2_table[idx+1];
        return longint'(p) * 65536 + a + floor_shift((b - a) * longint'(rem), 31);
    endfunction

    function automatic longint clamp16(longint x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    function automatic longint unsigned reg_or_one(int i);
        return cfg_regs[i] == 0 ? 1 : longint'(cfg_regs[i]);
    endfunction

    // one voltage in, one filtered reading out
    function automatic reading_t predict_reading(logic [VW-1:0] mv);
        reading_t r;
        longint unsigned v, supply, pull, beta, nom, t0, num;
        longint d, ln_q16, den, tck, temp_c, step;
        v = mv;
        supply = cfg_regs[REG_SUPPLY];
        r.fault = 1'b0;
        if (v == 0 || v >= supply) begin
            r.fault = 1'b1;
        end else begin
            pull = reg_or_one(REG_PULLUP);
            beta = reg_or_one(REG_BETA);
            nom  = reg_or_one(REG_NOMINAL);
            t0   = reg_or_one(REG_T0);
            d = log2_fixed(pull * v) - log2_fixed((supply - v) * nom);
            ln_q16 = floor_shift(d * LN2_Q30 + (64'sd1 << 29), 30);
            den = longint'(100 * beta * 65536) + longint'(t0) * ln_q16;
            if (den <= 0) begin
                temp_c = 32767;
            end else begin
                num = 100 * beta * t0 * 65536;
                tck = longint'((num + longint'(den) / 2) / longint'(den));
                temp_c = clamp16(tck - 27315);
            end
            step = floor_shift(longint'(cfg_regs[REG_ALPHA]) * (temp_c - ema_temp) + 32768, 16);
            ema_temp = 16'(clamp16(longint'(ema_temp) + step));
        end
        r.temp = ema_temp;
        return r;
    endfunction

    // generous cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("%0t timeout", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    // driver: offers queued voltages with random gaps
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready_seen) begin
                if (voltage_q.size() > 0 && gap_left == 0) begin
                    s_tdata  <= {4'b0, voltage_q.pop_front()};
                    s_tvalid <= 1'b1;
                    gap_left <= ($urandom_range(0, 3) == 0) ?
                        (($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(1, 3)) : 0;
                end else begin
                    // beat taken at the last rising edge, or idle gap
                    s_tvalid <= 1'b0;
                    if (gap_left > 0 && voltage_q.size() > 0)
                        gap_left <= gap_left - 1;
                end
            end
        end
    end

    // sampled handshake for the driver
    always @(posedge aclk) begin
        s_tready_seen <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
            reading_q.push_back(predict_reading(s_tdata[VW-1:0]));
    end

    // receiver stall pattern, with one long hold while the sender keeps going
    always @(negedge aclk) begin
        if (aresetn) begin
            if (long_hold_req && hold_left == 0) begin
                hold_left <= 2000;
                long_hold_req <= 0;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= (hold_left == 1);
            end else if ($urandom_range(0, 49) == 0) begin
                hold_left <= $urandom_range(5, 40);
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 4) != 0) ||
                            ($urandom_range(0, 1) == 0);
            end
        end
    end

    // monitor: check each result beat against the oldest prediction
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (reading_q.size() == 0) begin
                $display("%0t unexpected beat temp=%0d fault=%0b",
                         $time, $signed(m_tdata), m_tuser[0]);
                fail_count <= fail_count + 1;
            end else begin
                want = reading_q.pop_front();
                if (m_tdata !== want.temp || m_tuser[0] !== want.fault) begin
                    $display("%0t mismatch expected temp=%0d fault=%0b actual temp=%0d fault=%0b",
                             $time, want.temp, want.fault, $signed(m_tdata), m_tuser[0]);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    function automatic int reg_width(logic [2:0] idx);
        case (idx)
            REG_PULLUP:  return PULLW;
            REG_BETA:    return BETAW;
            REG_NOMINAL: return NOMW;
            REG_T0:      return T0W;
            REG_ALPHA:   return ALPHAW;
            default:     return SUPW;
        endcase
    endfunction

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx < 6) cfg_regs[idx] = 32'(value & ((64'd1 << reg_width(idx)) - 1));
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // wait until every queued voltage is answered, then let the divider settle
    task automatic drain();
        while (voltage_q.size() > 0 || s_tvalid || reading_q.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic push_random(int count, logic [11:0] supply);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0:       voltage_q.push_back(12'($urandom_range(0, 4095)));
                1:       voltage_q.push_back(12'd0);
                2:       voltage_q.push_back(supply);
                default: voltage_q.push_back(12'($urandom_range(1, supply > 1 ? supply - 1 : 1)));
            endcase
        end
    endtask

    initial begin
        logic [11:0] sup;
        cfg_regs[REG_PULLUP]  = 10000;
        cfg_regs[REG_BETA]    = 3950;
        cfg_regs[REG_NOMINAL] = 10000;
        cfg_regs[REG_T0]      = 29815;
        cfg_regs[REG_ALPHA]   = 6554;
        cfg_regs[REG_SUPPLY]  = 3300;
        ema_temp = 2500;
        for (int i = 0; i <= TABLE_N; i++)
            log2_table[i] = unit_log2(((64'(TABLE_N) + i) << 30) / TABLE_N);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, faults, supply edges under reset settings
        voltage_q.push_back(12'd0);
        voltage_q.push_back(12'd1);
        voltage_q.push_back(12'd2);
        voltage_q.push_back(12'd1650);
        voltage_q.push_back(12'd3299);
        voltage_q.push_back(12'd3300);
        voltage_q.push_back(12'd3301);
        voltage_q.push_back(12'd4095);
        voltage_q.push_back(12'h555);
        voltage_q.push_back(12'hAAA);
        voltage_q.push_back(12'd100);
        voltage_q.push_back(12'd3200);
        drain();

        // zero registers are used as one; alpha extreme; full supply
        apb_write(REG_PULLUP, 0);
        apb_write(REG_BETA, 0);
        apb_write(REG_NOMINAL, 0);
        apb_write(REG_T0, 0);
        apb_write(REG_ALPHA, 16'hFFFF);
        apb_write(REG_SUPPLY, 12'hFFF);
        voltage_q.push_back(12'd1);
        voltage_q.push_back(12'd2048);
        voltage_q.push_back(12'd4094);
        voltage_q.push_back(12'd4095);
        drain();

        // non-positive beta denominator: small beta, tiny resistance ratio
        apb_write(REG_PULLUP, 1);
        apb_write(REG_BETA, 1);
        apb_write(REG_NOMINAL, 32'hFFFFF);
        apb_write(REG_T0, 16'hFFFF);
        apb_write(REG_ALPHA, 16'hFFFF);
        voltage_q.push_back(12'd4000);
        voltage_q.push_back(12'd10);
        drain();
        apb_write(REG_SUPPLY, 0);
        voltage_q.push_back(12'd5);    // zero supply faults everything
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    apb_write(REG_PULLUP, 10000); apb_write(REG_BETA, 3950);
                    apb_write(REG_NOMINAL, 10000); apb_write(REG_T0, 29815);
                    apb_write(REG_ALPHA, 6554); apb_write(REG_SUPPLY, 3300);
                end
                1: begin
                    apb_write(REG_PULLUP, 1000000); apb_write(REG_BETA, 10000);
                    apb_write(REG_NOMINAL, 1); apb_write(REG_T0, 65535);
                    apb_write(REG_ALPHA, 65535); apb_write(REG_SUPPLY, 4095);
                end
                2: begin
                    apb_write(REG_PULLUP, 1); apb_write(REG_BETA, 1);
                    apb_write(REG_NOMINAL, 1000000); apb_write(REG_T0, 1);
                    apb_write(REG_ALPHA, 1); apb_write(REG_SUPPLY, 1);
                end
                default: begin
                    apb_write(REG_PULLUP, $urandom_range(1, 32'hFFFFF));
                    apb_write(REG_BETA, $urandom_range(1, 16383));
                    apb_write(REG_NOMINAL, $urandom_range(1, 32'hFFFFF));
                    apb_write(REG_T0, $urandom_range(20000, 40000));
                    apb_write(REG_ALPHA, $urandom_range(0, 65535));
                    apb_write(REG_SUPPLY, $urandom_range(2, 4095));
                end
            endcase
            sup = 12'(cfg_regs[REG_SUPPLY]);
            if (ph == 3) long_hold_req = 1;
            push_random(140, sup);
            drain();
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ntcbte_pkg.sv
hdl/ntcbte_ctrl.sv
hdl/ntcbte_dp.sv
hdl/ntc_beta_temperature_ema_top.sv
test/ntc_beta_temperature_ema_top_test.sv
